// ----- design/sclt_pkg.sv -----
package sclt_pkg;

   typedef struct packed {
      logic        operation;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_count;
      logic [31:0] access_count;
   } rsp_type;

   typedef enum logic {
      OP_FIND,
      OP_FILL
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } seq_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } seq_sts_type;

   localparam logic [1:0] REG_WAY_LOG2   = 2'd0;
   localparam logic [1:0] REG_ALLOC_ST   = 2'd1;
   localparam logic [1:0] REG_PF_MODE    = 2'd2;

   localparam logic [1:0] PF_ALWAYS      = 2'd1;
   localparam logic [1:0] PF_ON_MISS     = 2'd2;

endpackage

// ----- design/sclt_tag_ram.sv -----
module sclt_tag_ram #(
   parameter int LINES = 512,
   parameter int EW    = 37
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(LINES)-1:0] rd_addr,
   output logic [EW-1:0]            rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(LINES)-1:0] wr_addr,
   input  logic [EW-1:0]            wr_data,
   output logic                     init_done
);
   import sclt_pkg::*;

   localparam int LL = $clog2(LINES);

   logic [EW-1:0] mem [LINES];
   logic [EW-1:0] rd_data_ff;
   logic [LL:0]   clr_ff;
   logic [LL:0]   clr_in;

   assign init_done = clr_ff[LL];
   assign rd_data   = rd_data_ff;
   assign clr_in    = clr_ff + 1'b1;

   // sweep invalidating every line after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (!clr_ff[LL]) begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!clr_ff[LL]) begin
         mem[clr_ff[LL-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- design/sclt_seq.sv -----
module sclt_seq #(
   parameter int LINES = 512,
   parameter int LW    = 27
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sclt_pkg::seq_cmd_type         cmd,
   input  logic [$clog2(LINES)-1:0]      base,
   input  logic [LW-1:0]                 tag,
   input  logic [$clog2(LINES):0]        ways,
   output sclt_pkg::seq_sts_type         sts,
   output logic                          rd_en,
   output logic [$clog2(LINES)-1:0]      rd_addr,
   input  logic [LW+$clog2(LINES):0]     rd_data,
   output logic                          wr_en,
   output logic [$clog2(LINES)-1:0]      wr_addr,
   output logic [LW+$clog2(LINES):0]     wr_data
);
   import sclt_pkg::*;

   localparam int LL = $clog2(LINES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPD
   } state_type;

   state_type     state_ff;
   op_type        op_ff;
   logic [LL:0]   iss_ff;
   logic          rd_vld_ff;
   logic [LL-1:0] rd_way_ff;
   logic          found_ff, found_in;
   logic [LL-1:0] fway_ff, fway_in;
   logic [LL-1:0] former_ff, former_in;
   logic          inv_ff, inv_in;
   logic [LL-1:0] inv_way_ff, inv_way_in;
   logic [LL-1:0] best_ff, best_in;
   logic [LL-1:0] victim_ff, victim_in;
   logic          fill_inv_ff;
   logic [LL-1:0] tgt_ff;
   logic          done_ff;
   logic          found_out_ff;

   logic          e_valid;
   logic [LW-1:0] e_tag;
   logic [LL-1:0] e_rank;
   logic          last;
   logic [LL:0]   ways_m1;
   logic [LL-1:0] n_rank;
   logic [LW-1:0] n_tag;
   logic          n_valid;

   assign {e_valid, e_tag, e_rank} = rd_data;
   assign ways_m1 = ways - 1'b1;
   assign last    = rd_vld_ff && (rd_way_ff == ways_m1[LL-1:0]);
   assign rd_en   = ((state_ff == S_SCAN) || (state_ff == S_UPD)) && (iss_ff < ways);
   assign rd_addr = base + iss_ff[LL-1:0];
   assign wr_en   = (state_ff == S_UPD) && rd_vld_ff;
   assign wr_addr = base + rd_way_ff;
   assign wr_data = {n_valid, n_tag, n_rank};
   assign sts.done  = done_ff;
   assign sts.found = found_out_ff;

   // scan trackers
   always_comb begin
      found_in   = found_ff;
      fway_in    = fway_ff;
      former_in  = former_ff;
      inv_in     = inv_ff;
      inv_way_in = inv_way_ff;
      best_in    = best_ff;
      victim_in  = victim_ff;
      if (rd_vld_ff) begin
         if (e_valid && (e_tag == tag) && !found_ff) begin
            found_in  = 1'b1;
            fway_in   = rd_way_ff;
            former_in = e_rank;
         end
         if (!e_valid && !inv_ff) begin
            inv_in     = 1'b1;
            inv_way_in = rd_way_ff;
         end
         if ((rd_way_ff == '0) || (e_rank > best_ff)) begin
            best_in   = e_rank;
            victim_in = rd_way_ff;
         end
      end
   end

   // rank update of one way
   always_comb begin
      n_valid = e_valid;
      n_tag   = e_tag;
      n_rank  = e_rank;
      if (op_ff == OP_FIND) begin
         if (rd_way_ff == fway_ff) begin
            n_rank = '0;
         end else if (e_valid && (e_rank < former_ff)) begin
            n_rank = e_rank + 1'b1;
         end
      end else if (fill_inv_ff) begin
         if (rd_way_ff == tgt_ff) begin
            n_valid = 1'b1;
            n_tag   = tag;
            n_rank  = '0;
         end else if ((rd_way_ff < tgt_ff) && e_valid) begin
            n_rank = e_rank + 1'b1;
         end
      end else begin
         if (rd_way_ff == tgt_ff) begin
            n_tag  = tag;
            n_rank = '0;
         end else if (e_valid) begin
            n_rank = e_rank + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (rd_en) begin
            rd_way_ff <= iss_ff[LL-1:0];
            iss_ff    <= iss_ff + 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               done_ff <= 1'b0;
               if (cmd.start) begin
                  op_ff    <= cmd.op;
                  iss_ff   <= '0;
                  found_ff <= 1'b0;
                  inv_ff   <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               found_ff   <= found_in;
               fway_ff    <= fway_in;
               former_ff  <= former_in;
               inv_ff     <= inv_in;
               inv_way_ff <= inv_way_in;
               best_ff    <= best_in;
               victim_ff  <= victim_in;
               if (last) begin
                  if ((op_ff == OP_FIND) && (!found_in || (former_in == '0))) begin
                     done_ff      <= 1'b1;
                     found_out_ff <= found_in;
                     state_ff     <= S_IDLE;
                  end else begin
                     fill_inv_ff <= inv_in;
                     tgt_ff      <= inv_in ? inv_way_in : victim_in;
                     iss_ff      <= '0;
                     state_ff    <= S_UPD;
                  end
               end
            end
            S_UPD: begin
               if (last) begin
                  done_ff      <= 1'b1;
                  found_out_ff <= found_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- design/set_assoc_lru_cache_tags.sv -----
// each item runs a demand lookup and, as misses, store allocation and the prefetch
// mode call for, next-line lookups and fills before its result is registered
// one item at a time; the next item is taken the cycle after the
// result is registered
// reset: synchronous; a sweep invalidates all lines
// before the first item is taken, configuration writes are taken throughout
module set_assoc_lru_cache_tags #(
   parameter int TOTAL_LINES      = 512,
   parameter int LINE_OFFSET_BITS = 5,
   parameter int ADDRESS_BITS     = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sclt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sclt_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import sclt_pkg::*;

   localparam int LL    = $clog2(TOTAL_LINES);
   localparam int LW    = ADDRESS_BITS - LINE_OFFSET_BITS;
   localparam int EW    = 1 + LW + LL;
   localparam int EXT_W = (ADDRESS_BITS > 32) ? ADDRESS_BITS : 32;

   typedef enum logic [2:0] {
      T_IDLE,
      T_PREP,
      T_DFIND,
      T_NFIND,
      T_DFILL,
      T_NFILL,
      T_RESP
   } state_type;

   state_type     state_ff;
   logic [3:0]    way_log2_ff;
   logic          alloc_st_ff;
   logic [1:0]    pf_mode_ff;
   req_type       in_ff;
   logic [LL-1:0] d_base_ff, n_base_ff;
   logic [LW-1:0] d_tag_ff, n_tag_ff;
   logic [LL:0]   ways_ff;
   logic          issued_ff;
   logic          hit_ff;
   logic          nfound_ff;
   logic [31:0]   hit_cnt_ff, acc_cnt_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [EXT_W-1:0]        addr_ext;
   logic [ADDRESS_BITS-1:0] addr_m;
   logic [LW-1:0]           line, nline;
   logic [3:0]              wl_eff, set_bits;
   logic                    fill_d;
   logic                    cfg_wr;

   seq_cmd_type   cmd;
   seq_sts_type   sts;
   logic [LL-1:0] op_base;
   logic [LW-1:0] op_tag;
   logic          rd_en, wr_en, init_done;
   logic [LL-1:0] rd_addr, wr_addr;
   logic [EW-1:0] rd_data, wr_data;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         REG_WAY_LOG2: prdata = {28'd0, way_log2_ff};
         REG_ALLOC_ST: prdata = {31'd0, alloc_st_ff};
         REG_PF_MODE:  prdata = {30'd0, pf_mode_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         way_log2_ff <= 4'd1;
         alloc_st_ff <= 1'b1;
         pf_mode_ff  <= '0;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_WAY_LOG2: way_log2_ff <= pwdata[3:0];
            REG_ALLOC_ST: alloc_st_ff <= pwdata[0];
            REG_PF_MODE:  pf_mode_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // set geometry and tags
   assign addr_ext = EXT_W'(in_ff.address);
   assign addr_m   = addr_ext[ADDRESS_BITS-1:0];
   assign line     = addr_m[ADDRESS_BITS-1:LINE_OFFSET_BITS];
   assign nline    = line + 1'b1;
   assign wl_eff   = (way_log2_ff > 4'(LL)) ? 4'(LL) : way_log2_ff;
   assign set_bits = 4'(LL) - wl_eff;
   assign fill_d   = !hit_ff && (!in_ff.operation || alloc_st_ff);

   assign req_stall   = !((state_ff == T_IDLE) && init_done);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cmd.start = ((state_ff == T_DFIND) || (state_ff == T_NFIND) ||
                       (state_ff == T_DFILL) || (state_ff == T_NFILL)) && !issued_ff;
   assign cmd.op    = ((state_ff == T_DFILL) || (state_ff == T_NFILL)) ? OP_FILL : OP_FIND;
   assign op_base   = ((state_ff == T_NFIND) || (state_ff == T_NFILL)) ? n_base_ff : d_base_ff;
   assign op_tag    = ((state_ff == T_NFIND) || (state_ff == T_NFILL)) ? n_tag_ff : d_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         issued_ff    <= 1'b0;
         hit_cnt_ff   <= '0;
         acc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != T_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.start) begin
            issued_ff <= 1'b1;
         end
         if (sts.done) begin
            issued_ff <= 1'b0;
         end
         case (state_ff)
            T_IDLE: begin
               if (req_valid && !req_stall) begin
                  in_ff    <= req_payload;
                  state_ff <= T_PREP;
               end
            end
            T_PREP: begin
               d_base_ff  <= LL'(line[LL-1:0] << wl_eff);
               n_base_ff  <= LL'(nline[LL-1:0] << wl_eff);
               d_tag_ff   <= line >> set_bits;
               n_tag_ff   <= nline >> set_bits;
               ways_ff    <= (LL+1)'(1) << wl_eff;
               acc_cnt_ff <= acc_cnt_ff + 1'b1;
               state_ff   <= T_DFIND;
            end
            T_DFIND: begin
               if (sts.done) begin
                  hit_ff <= sts.found;
                  if (sts.found) begin
                     hit_cnt_ff <= hit_cnt_ff + 1'b1;
                  end
                  if (pf_mode_ff == PF_ALWAYS) begin
                     state_ff <= T_NFIND;
                  end else if (!sts.found && (!in_ff.operation || alloc_st_ff)) begin
                     state_ff <= T_DFILL;
                  end else if ((pf_mode_ff == PF_ON_MISS) && !sts.found) begin
                     state_ff <= T_NFIND;
                  end else begin
                     state_ff <= T_RESP;
                  end
               end
            end
            T_NFIND: begin
               if (sts.done) begin
                  nfound_ff <= sts.found;
                  if ((pf_mode_ff == PF_ALWAYS) && fill_d) begin
                     state_ff <= T_DFILL;
                  end else if (!sts.found) begin
                     state_ff <= T_NFILL;
                  end else begin
                     state_ff <= T_RESP;
                  end
               end
            end
            T_DFILL: begin
               if (sts.done) begin
                  if (pf_mode_ff == PF_ALWAYS) begin
                     state_ff <= nfound_ff ? T_RESP : T_NFILL;
                  end else if (pf_mode_ff == PF_ON_MISS) begin
                     state_ff <= T_NFIND;
                  end else begin
                     state_ff <= T_RESP;
                  end
               end
            end
            T_NFILL: begin
               if (sts.done) begin
                  state_ff <= T_RESP;
               end
            end
            T_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.hit          <= hit_ff;
                  rsp_ff.hit_count    <= hit_cnt_ff;
                  rsp_ff.access_count <= acc_cnt_ff;
                  state_ff            <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   sclt_seq #(
      .LINES (TOTAL_LINES),
      .LW    (LW)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .base    (op_base),
      .tag     (op_tag),
      .ways    (ways_ff),
      .sts     (sts),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   sclt_tag_ram #(
      .LINES (TOTAL_LINES),
      .EW    (EW)
   ) u_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .init_done (init_done)
   );

   a_no_item_during_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> init_done)
      else $error("item taken before tag sweep finished");

   a_done_only_when_issued: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> issued_ff)
      else $error("set operation finished without being started");

   a_access_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_PREP) |=> (acc_cnt_ff == $past(acc_cnt_ff) + 32'd1))
      else $error("access count did not advance");

endmodule
